// ===== sv/v3au_pkg.sv =====
// ----------------------------------------------------------------------------
// v3au_pkg
// Shared types, codes and the 32-bit saturation helper for the vector unit.
// ----------------------------------------------------------------------------
package v3au_pkg;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_NEG   = 4'd2,
    OP_SCALE = 4'd3,
    OP_DIV   = 4'd4,
    OP_DOT   = 4'd5,
    OP_CROSS = 4'd6,
    OP_MAG   = 4'd7,
    OP_NORM  = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIVZ = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  localparam int unsigned SQRT_STAGES = 32;
  localparam int unsigned SQRT_LAT    = SQRT_STAGES + 1;
  localparam int unsigned DEN_W       = 32;

  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } sat_t;

  function automatic sat_t sat32(input logic signed [65:0] v);
    sat_t r;
    r.val = v[31:0];
    r.sat = 1'b0;
    if (v > SAT_MAX) begin
      r.val = 32'h7fff_ffff;
      r.sat = 1'b1;
    end else if (v < SAT_MIN) begin
      r.val = 32'h8000_0000;
      r.sat = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== sv/v3au_lane.sv =====
// ----------------------------------------------------------------------------
// v3au_lane
// One component lane: two multipliers, then add/sub/negate/scale/cross
// result with rounding and saturation. Two register stages.
// ----------------------------------------------------------------------------
module v3au_lane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  v3au_pkg::op_e      op_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  input  logic signed [31:0] s_i,
  input  logic signed [31:0] ca_i,
  input  logic signed [31:0] cb_i,
  input  logic signed [31:0] cc_i,
  input  logic signed [31:0] cd_i,
  output logic signed [63:0] p1_o,
  output logic [31:0]        res_o,
  output logic               sat_o
);
  import v3au_pkg::*;

  localparam logic signed [65:0] RHALF = 66'sd1 <<< (FRAC_BITS - 1);

  logic signed [31:0] m1a, m1b;
  op_e                op_q;
  logic signed [31:0] a_q, b_q;
  logic signed [63:0] p1_q, p2_q;
  logic signed [65:0] v;
  sat_t               vs;
  logic [31:0]        res_q;
  logic               sat_q;

  always_comb begin
    m1a = a_i;
    m1b = a_i;
    case (op_i)
      OP_SCALE: m1b = s_i;
      OP_DOT:   m1b = b_i;
      OP_CROSS: begin
        m1a = ca_i;
        m1b = cb_i;
      end
      default: m1b = a_i;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q <= op_i;
      a_q  <= a_i;
      b_q  <= b_i;
      p1_q <= 64'(m1a) * 64'(m1b);
      p2_q <= 64'(cc_i) * 64'(cd_i);
    end
  end

  always_comb begin
    case (op_q)
      OP_ADD:   v = 66'(a_q) + 66'(b_q);
      OP_SUB:   v = 66'(a_q) - 66'(b_q);
      OP_NEG:   v = -66'(a_q);
      OP_SCALE: v = (66'(p1_q) + RHALF) >>> FRAC_BITS;
      OP_CROSS: v = (66'(p1_q) - 66'(p2_q) + RHALF) >>> FRAC_BITS;
      default:  v = '0;
    endcase
    vs = sat32(v);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= vs.val;
      sat_q <= vs.sat;
    end
  end

  assign p1_o  = p1_q;
  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule

// ===== sv/v3au_sqrt.sv =====
// ----------------------------------------------------------------------------
// v3au_sqrt
// Pipelined integer square root of a 64-bit value, one root bit per stage,
// plus a final stage that rounds to nearest.
// ----------------------------------------------------------------------------
module v3au_sqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] rad_i,
  output logic [32:0] root_o
);
  import v3au_pkg::*;

  logic [63:0] rad_q  [SQRT_STAGES];
  logic [33:0] rem_q  [SQRT_STAGES];
  logic [31:0] root_q [SQRT_STAGES];
  logic [32:0] rnd_q;

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stg
    logic [63:0] rad_in;
    logic [33:0] rem_in;
    logic [31:0] root_in;
    logic [35:0] t, trial;
    logic        ge;

    if (g == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
    end

    assign t     = {rem_in, rad_in[63:62]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = t >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[g]  <= {rad_in[61:0], 2'b00};
        rem_q[g]  <= ge ? 34'(t - trial) : t[33:0];
        root_q[g] <= {root_in[30:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rnd_q <= (rem_q[SQRT_STAGES-1] > 34'(root_q[SQRT_STAGES-1]))
             ? 33'(root_q[SQRT_STAGES-1]) + 33'd1
             : 33'(root_q[SQRT_STAGES-1]);
    end
  end

  assign root_o = rnd_q;

endmodule

// ===== sv/v3au_div.sv =====
// ----------------------------------------------------------------------------
// v3au_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module v3au_div #(
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 32
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] quo_o
);

  logic [NW-1:0] nq_q  [NW];
  logic [DW-1:0] rem_q [NW];
  logic [DW-1:0] den_q [NW];

  for (genvar g = 0; g < NW; g++) begin : g_stg
    logic [NW-1:0] nq_in;
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   t, dx;
    logic          ge;

    if (g == 0) begin : g_first
      assign nq_in  = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign nq_in  = nq_q[g-1];
      assign rem_in = rem_q[g-1];
      assign den_in = den_q[g-1];
    end

    assign t  = {rem_in, nq_in[NW-1]};
    assign dx = {1'b0, den_in};
    assign ge = t >= dx;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[g]  <= {nq_in[NW-2:0], ge};
        rem_q[g] <= ge ? DW'(t - dx) : t[DW-1:0];
        den_q[g] <= den_in;
      end
    end
  end

  assign quo_o = nq_q[NW-1];

endmodule

// ===== sv/vector3_arithmetic_unit.sv =====
// Throughput: one beat per cycle while the output is not stalled; the pipeline length is set by the
// 33-stage square root followed by the (32 + FRAC_BITS)-stage dividers.
// A stalled output register freezes the whole pipeline.
// Reset clears only the stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit
// Three-lane Q-format vector ALU: add, sub, negate, scale, divide, dot,
// cross, magnitude and normalize with saturation and status.
// ----------------------------------------------------------------------------
module vector3_arithmetic_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // op[3:0], ax, ay, az, bx, by_comp, bz, scale (32 each), zero pad
  input  logic [231:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // rx, ry, rz, scalar_result (32 each), status[1:0], zero pad
  output logic [135:0] m_axis_tdata
);
  import v3au_pkg::*;

  localparam int unsigned NW  = 32 + FRAC_BITS;
  localparam int unsigned LAT = 2 + SQRT_LAT + 1 + NW + 1;
  localparam logic signed [65:0] RHALF = 66'sd1 <<< (FRAC_BITS - 1);

  typedef struct packed {
    op_e              op;
    logic [2:0][31:0] na;
    logic [2:0]       aneg;
    logic [31:0]      sabs;
    logic             sneg;
    logic             szero;
  } s1_t;

  typedef struct packed {
    op_e              op;
    logic [2:0][31:0] r;
    logic [31:0]      sc;
    logic             sat;
    logic [2:0][31:0] na;
    logic [2:0]       aneg;
    logic [31:0]      sabs;
    logic             sneg;
    logic             szero;
  } sd_t;

  typedef struct packed {
    op_e              op;
    logic [2:0][31:0] r;
    logic [31:0]      sc;
    logic             sat;
    logic [2:0]       qneg;
    logic             dz;
  } pd_t;

  logic               en;
  logic [LAT-1:0]     vld_q;
  logic signed [31:0] a [3];
  logic signed [31:0] b [3];
  logic signed [31:0] s;
  op_e                op_in;
  s1_t                s1_d, s1_q, s2_q;
  logic signed [63:0] p1 [3];
  logic [31:0]        lres [3];
  logic [2:0]         lsat;
  sat_t               dot_q;
  logic [63:0]        ss_q;
  sd_t                sd_in;
  sd_t                sd_q [SQRT_LAT];
  logic [32:0]        root;
  sd_t                sd_o;
  pd_t                pd_d, pd0_q;
  pd_t                pd_q [NW];
  logic [31:0]        den_d, den_q;
  logic [NW-1:0]      num_d [3];
  logic [NW-1:0]      num_q [3];
  logic [NW-1:0]      quo [3];
  logic               magsat;
  pd_t                pf;
  logic [2:0][31:0]   rf;
  logic               satf;
  sat_t               qs [3];
  logic [1:0]         stf;
  logic [135:0]       out_q;

  assign en            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // input unpack and sign/magnitude split for the dividers
  always_comb begin
    op_in = op_e'(s_axis_tdata[3:0]);
    for (int i = 0; i < 3; i++) begin
      a[i] = s_axis_tdata[4 + 32*i +: 32];
      b[i] = s_axis_tdata[100 + 32*i +: 32];
    end
    s = s_axis_tdata[227:196];
    s1_d.op = op_in;
    for (int i = 0; i < 3; i++) begin
      s1_d.aneg[i] = a[i][31];
      s1_d.na[i]   = a[i][31] ? 32'(-a[i]) : a[i];
    end
    s1_d.sneg  = s[31];
    s1_d.sabs  = s[31] ? 32'(-s) : s;
    s1_d.szero = (s == '0);
  end

  v3au_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
    .clk_i, .en_i(en), .op_i(op_in), .a_i(a[0]), .b_i(b[0]), .s_i(s),
    .ca_i(a[1]), .cb_i(b[2]), .cc_i(a[2]), .cd_i(b[1]),
    .p1_o(p1[0]), .res_o(lres[0]), .sat_o(lsat[0])
  );
  v3au_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
    .clk_i, .en_i(en), .op_i(op_in), .a_i(a[1]), .b_i(b[1]), .s_i(s),
    .ca_i(a[2]), .cb_i(b[0]), .cc_i(a[0]), .cd_i(b[2]),
    .p1_o(p1[1]), .res_o(lres[1]), .sat_o(lsat[1])
  );
  v3au_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
    .clk_i, .en_i(en), .op_i(op_in), .a_i(a[2]), .b_i(b[2]), .s_i(s),
    .ca_i(a[0]), .cb_i(b[1]), .cc_i(a[1]), .cd_i(b[0]),
    .p1_o(p1[2]), .res_o(lres[2]), .sat_o(lsat[2])
  );

  // merge: dot product and sum of squares
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q  <= s1_d;
      s2_q  <= s1_q;
      dot_q <= sat32((66'(p1[0]) + 66'(p1[1]) + 66'(p1[2]) + RHALF) >>> FRAC_BITS);
      ss_q  <= $unsigned(p1[0]) + $unsigned(p1[1]) + $unsigned(p1[2]);
    end
  end

  always_comb begin
    sd_in.op    = s2_q.op;
    for (int i = 0; i < 3; i++) sd_in.r[i] = lres[i];
    sd_in.sc    = (s2_q.op == OP_DOT) ? dot_q.val : '0;
    sd_in.sat   = (|lsat) || ((s2_q.op == OP_DOT) && dot_q.sat);
    sd_in.na    = s2_q.na;
    sd_in.aneg  = s2_q.aneg;
    sd_in.sabs  = s2_q.sabs;
    sd_in.sneg  = s2_q.sneg;
    sd_in.szero = s2_q.szero;
  end

  v3au_sqrt u_sqrt (.clk_i, .en_i(en), .rad_i(ss_q), .root_o(root));

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= sd_in;
      for (int k = 1; k < SQRT_LAT; k++) sd_q[k] <= sd_q[k-1];
    end
  end

  // post-root: magnitude result, divisor select, rounded numerators
  always_comb begin
    sd_o    = sd_q[SQRT_LAT-1];
    magsat  = root > 33'd2147483647;
    pd_d.op = sd_o.op;
    pd_d.r  = sd_o.r;
    pd_d.sc = sd_o.sc;
    pd_d.sat = sd_o.sat;
    if (sd_o.op == OP_MAG) begin
      pd_d.sc  = magsat ? 32'h7fff_ffff : root[31:0];
      pd_d.sat = magsat;
    end
    for (int i = 0; i < 3; i++) begin
      pd_d.qneg[i] = sd_o.aneg[i] ^ ((sd_o.op == OP_DIV) && sd_o.sneg);
    end
    pd_d.dz = ((sd_o.op == OP_DIV) && sd_o.szero) || ((sd_o.op == OP_NORM) && (root == '0));
    den_d   = (sd_o.op == OP_DIV) ? sd_o.sabs : root[31:0];
    for (int i = 0; i < 3; i++) begin
      num_d[i] = (NW'(sd_o.na[i]) << FRAC_BITS) + NW'(den_d >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pd0_q <= pd_d;
      den_q <= den_d;
      for (int i = 0; i < 3; i++) num_q[i] <= num_d[i];
      pd_q[0] <= pd0_q;
      for (int k = 1; k < NW; k++) pd_q[k] <= pd_q[k-1];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    v3au_div #(.NW(NW), .DW(DEN_W)) u_div (
      .clk_i, .en_i(en), .num_i(num_q[i]), .den_i(den_q), .quo_o(quo[i])
    );
  end

  // final sign, saturation and status
  always_comb begin
    pf   = pd_q[NW-1];
    rf   = pf.r;
    satf = pf.sat;
    for (int i = 0; i < 3; i++) begin
      qs[i] = sat32(pf.qneg[i] ? -$signed(66'(quo[i])) : $signed(66'(quo[i])));
      if (((pf.op == OP_DIV) || (pf.op == OP_NORM)) && !pf.dz) begin
        rf[i] = qs[i].val;
        satf  = satf || qs[i].sat;
      end
    end
    if (pf.dz) begin
      stf = ST_DIVZ;
    end else if (satf) begin
      stf = ST_SAT;
    end else begin
      stf = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= {6'b0, stf, pf.sc, rf[2], rf[1], rf[0]};
    end
  end

  a_divz_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[129:128] == ST_DIVZ)) |-> (m_axis_tdata[127:0] == '0))
    else $error("divide-by-zero beat carries nonzero data");

  a_status_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[129:128] == ST_OK) || (m_axis_tdata[129:128] == ST_DIVZ)
                       || (m_axis_tdata[129:128] == ST_SAT)))
    else $error("undefined status code");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> (vld_q == $past(vld_q)))
    else $error("pipeline moved during stall");

endmodule
